// ===== hdl/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// Shared constants, payload types and opcode helpers for the stack core.
// ----------------------------------------------------------------------------
package psm_pkg;

   localparam int MEM_WORDS   = 65536;
   localparam int MEM_AW      = 16;
   localparam int STACK_DEPTH = 1024;
   localparam int STACK_AW    = 10;
   localparam int DEPTH_W     = 11;
   localparam int IP_W        = 17;
   localparam int WORD_W      = 32;

   localparam logic [31:0] IO_COUNT = 32'd2;
   localparam logic [31:0] MAX_INT  = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_INT  = 32'h8000_0000;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_EXEC  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] OP_NOP     = 8'd0;
   localparam logic [7:0] OP_LIT     = 8'd1;
   localparam logic [7:0] OP_DUP     = 8'd2;
   localparam logic [7:0] OP_DROP    = 8'd3;
   localparam logic [7:0] OP_SWAP    = 8'd4;
   localparam logic [7:0] OP_PUSH    = 8'd5;
   localparam logic [7:0] OP_POP     = 8'd6;
   localparam logic [7:0] OP_JUMP    = 8'd7;
   localparam logic [7:0] OP_CALL    = 8'd8;
   localparam logic [7:0] OP_CCALL   = 8'd9;
   localparam logic [7:0] OP_RET     = 8'd10;
   localparam logic [7:0] OP_EQ      = 8'd11;
   localparam logic [7:0] OP_NE      = 8'd12;
   localparam logic [7:0] OP_LT      = 8'd13;
   localparam logic [7:0] OP_GT      = 8'd14;
   localparam logic [7:0] OP_FETCH   = 8'd15;
   localparam logic [7:0] OP_STORE   = 8'd16;
   localparam logic [7:0] OP_ADD     = 8'd17;
   localparam logic [7:0] OP_SUB     = 8'd18;
   localparam logic [7:0] OP_MUL     = 8'd19;
   localparam logic [7:0] OP_DIVMOD  = 8'd20;
   localparam logic [7:0] OP_AND     = 8'd21;
   localparam logic [7:0] OP_OR      = 8'd22;
   localparam logic [7:0] OP_XOR     = 8'd23;
   localparam logic [7:0] OP_SHIFT   = 8'd24;
   localparam logic [7:0] OP_ZRET    = 8'd25;
   localparam logic [7:0] OP_HALT    = 8'd26;
   localparam logic [7:0] OP_IOCOUNT = 8'd27;
   localparam logic [7:0] OP_IOQUERY = 8'd28;
   localparam logic [7:0] OP_IO      = 8'd29;

   localparam logic [2:0] FAULT_NONE   = 3'd0;
   localparam logic [2:0] FAULT_HALT   = 3'd1;
   localparam logic [2:0] FAULT_OPCODE = 3'd2;
   localparam logic [2:0] FAULT_DSTACK = 3'd3;
   localparam logic [2:0] FAULT_RSTACK = 3'd4;
   localparam logic [2:0] FAULT_RANGE  = 3'd5;
   localparam logic [2:0] FAULT_DIV0   = 3'd6;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [15:0]        mem_addr;
      logic signed [31:0] mem_value;
      logic signed [7:0]  key_char;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               char_valid;
      logic [7:0]         char_out;
      logic               halted;
      logic [2:0]         fault_code;
      logic [16:0]        pc;
   } rsp_type;

   function automatic logic op_valid(input logic [7:0] op);
      return op <= OP_IO;
   endfunction

   // number of data stack entries taken before the operation runs
   function automatic logic [1:0] op_pops(input logic [7:0] op);
      logic [1:0] n;
      n = 2'd0;
      case (op) inside
         OP_SWAP, OP_CCALL, OP_EQ, OP_NE, OP_LT, OP_GT, OP_STORE, OP_ADD,
         OP_SUB, OP_MUL, OP_DIVMOD, OP_AND, OP_OR, OP_XOR, OP_SHIFT: n = 2'd2;
         OP_DUP, OP_DROP, OP_PUSH, OP_JUMP, OP_CALL, OP_FETCH, OP_ZRET,
         OP_IOQUERY, OP_IO: n = 2'd1;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== hdl/psm_ram.sv =====
// ----------------------------------------------------------------------------
// psm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/packed_stack_machine_core.sv =====
// ----------------------------------------------------------------------------
// packed_stack_machine_core
// Dual-stack processor, four 8-bit opcodes per program word, one slot per item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req_     | in        | req_valid / req_stall | psm_pkg::req_type
//  rsp_     | out       | rsp_valid / rsp_stall | psm_pkg::rsp_type
//
//  write: idle, finish; read: ram read, finish; slot: word fetch at slot 0,
//  decode, two pops, exec, push check, pushes; divmod adds a restoring divider.
//  the steps are set by the single read port of each stack and program ram.
//  one item in flight; req_stall is high from acceptance until the result is
//  registered, and a stalled rsp holds the core in its last state.
//  synchronous reset clears control state; rams start undefined, no clear pass.
module packed_stack_machine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psm_pkg::rsp_type  rsp_data
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_MRD    = 14'b00000000000010,
      ST_LATCH  = 14'b00000000000100,
      ST_DECODE = 14'b00000000001000,
      ST_POPA   = 14'b00000000010000,
      ST_POPB   = 14'b00000000100000,
      ST_EXEC   = 14'b00000001000000,
      ST_MEMQ   = 14'b00000010000000,
      ST_DIV    = 14'b00000100000000,
      ST_DIVFIX = 14'b00001000000000,
      ST_PCHK   = 14'b00010000000000,
      ST_PUSH1  = 14'b00100000000000,
      ST_PUSH2  = 14'b01000000000000,
      ST_FINISH = 14'b10000000000000
   } state_type;

   localparam int DW = psm_pkg::DEPTH_W;
   localparam int IW = psm_pkg::IP_W;
   localparam int SW = psm_pkg::STACK_AW;
   localparam int MW = psm_pkg::MEM_AW;

   state_type        state_ff, state_in;
   psm_pkg::req_type req_ff, req_in;
   psm_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      bundle_ff, bundle_in;
   logic [1:0]       slot_ff, slot_in;
   logic [IW-1:0]    ip_ff, ip_in;
   logic [DW-1:0]    ddep_ff, ddep_in;
   logic [DW-1:0]    rdep_ff, rdep_in;
   logic             stop_ff, stop_in;
   logic [2:0]       fault_ff, fault_in;
   logic [31:0]      a_ff, a_in;
   logic [31:0]      b_ff, b_in;
   logic [31:0]      rtop_ff, rtop_in;
   logic [31:0]      v1_ff, v1_in;
   logic [31:0]      v2_ff, v2_in;
   logic [1:0]       npush_ff, npush_in;
   logic [32:0]      div_rem_ff, div_rem_in;
   logic [31:0]      div_quo_ff, div_quo_in;
   logic [31:0]      div_den_ff, div_den_in;
   logic [4:0]       div_cnt_ff, div_cnt_in;
   logic             div_qneg_ff, div_qneg_in;
   logic             div_rneg_ff, div_rneg_in;
   logic             cv_ff, cv_in;
   logic [7:0]       co_ff, co_in;
   logic [31:0]      rdval_ff, rdval_in;

   // ram ports
   logic          pm_we;
   logic [MW-1:0] pm_waddr, pm_raddr;
   logic [31:0]   pm_wdata, pm_q;
   logic          ds_we;
   logic [SW-1:0] ds_waddr, ds_raddr;
   logic [31:0]   ds_wdata, ds_q;
   logic          rs_we;
   logic [SW-1:0] rs_waddr, rs_raddr;
   logic [31:0]   rs_wdata, rs_q;

   logic [7:0]    op;
   logic [DW-1:0] ddep_m1, ddep_m2, rdep_m1;
   logic [IW-1:0] ip_inc;
   logic [31:0]   tgt;
   logic          tgt_ok;
   logic [IW-1:0] ip_tgt;
   logic [31:0]   ip_word;
   logic [31:0]   mul_res;
   logic [31:0]   sh_res;
   logic [31:0]   neg_a;
   logic [32:0]   div_sh;
   logic [DW:0]   push_end;
   logic          fire;

   assign op      = bundle_ff[{slot_ff, 3'b000} +: 8];
   assign ddep_m1 = ddep_ff - DW'(1);
   assign ddep_m2 = ddep_ff - DW'(2);
   assign rdep_m1 = rdep_ff - DW'(1);
   assign ip_inc  = ip_ff + IW'(1);
   assign ip_word = {{(32 - IW){ip_ff[IW-1]}}, ip_ff};
   assign tgt     = (op == psm_pkg::OP_RET || op == psm_pkg::OP_ZRET) ?
                    rtop_ff + 32'd1 : a_ff;
   assign tgt_ok  = !tgt[31] && (tgt < 32'(psm_pkg::MEM_WORDS));
   assign ip_tgt  = tgt[IW-1:0] - IW'(1);
   assign mul_res = b_ff * a_ff;
   assign neg_a   = 32'd0 - a_ff;
   assign div_sh  = {div_rem_ff[31:0], div_quo_ff[31]};
   assign push_end = {1'b0, ddep_ff} + (DW + 1)'(npush_ff);
   assign fire    = !rsp_valid_ff || !rsp_stall;

   // shift: counts below one go left, the rest arithmetic right, saturating
   always_comb begin
      if ($signed(a_ff) < 32'sd1) begin
         if ($signed(a_ff) < -32'sd31) begin
            sh_res = 32'd0;
         end else begin
            sh_res = b_ff << neg_a[4:0];
         end
      end else if ($signed(a_ff) >= 32'sd32) begin
         sh_res = {32{b_ff[31]}};
      end else begin
         sh_res = 32'($signed(b_ff) >>> a_ff[4:0]);
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      bundle_in   = bundle_ff;
      slot_in     = slot_ff;
      ip_in       = ip_ff;
      ddep_in     = ddep_ff;
      rdep_in     = rdep_ff;
      stop_in     = stop_ff;
      fault_in    = fault_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      rtop_in     = rtop_ff;
      v1_in       = v1_ff;
      v2_in       = v2_ff;
      npush_in    = npush_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_den_in  = div_den_ff;
      div_cnt_in  = div_cnt_ff;
      div_qneg_in = div_qneg_ff;
      div_rneg_in = div_rneg_ff;
      cv_in       = cv_ff;
      co_in       = co_ff;
      rdval_in    = rdval_ff;

      pm_we    = 1'b0;
      pm_waddr = req_ff.mem_addr[MW-1:0];
      pm_wdata = req_ff.mem_value;
      pm_raddr = ip_ff[MW-1:0];
      ds_we    = 1'b0;
      ds_waddr = ddep_ff[SW-1:0];
      ds_wdata = v1_ff;
      ds_raddr = ddep_m1[SW-1:0];
      rs_we    = 1'b0;
      rs_waddr = rdep_ff[SW-1:0];
      rs_wdata = a_ff;
      rs_raddr = rdep_m1[SW-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               cv_in    = 1'b0;
               co_in    = 8'd0;
               rdval_in = 32'd0;
               case (req_data.cmd)
                  psm_pkg::CMD_WRITE: begin
                     pm_we    = 1'b1;
                     pm_waddr = req_data.mem_addr[MW-1:0];
                     pm_wdata = req_data.mem_value;
                     state_in = ST_FINISH;
                  end
                  psm_pkg::CMD_READ: begin
                     pm_raddr = req_data.mem_addr[MW-1:0];
                     state_in = ST_MRD;
                  end
                  psm_pkg::CMD_EXEC: begin
                     if (stop_ff) begin
                        state_in = ST_FINISH;
                     end else if (slot_ff == 2'd0) begin
                        pm_raddr = ip_ff[MW-1:0];
                        state_in = ST_LATCH;
                     end else begin
                        state_in = ST_DECODE;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_MRD: begin
            rdval_in = pm_q;
            state_in = ST_FINISH;
         end
         ST_LATCH: begin
            bundle_in = pm_q;
            state_in  = ST_DECODE;
         end
         ST_DECODE: begin
            if (!psm_pkg::op_valid(op)) begin
               stop_in  = 1'b1;
               fault_in = psm_pkg::FAULT_OPCODE;
               state_in = ST_FINISH;
            end else if (DW'(psm_pkg::op_pops(op)) > ddep_ff) begin
               stop_in  = 1'b1;
               fault_in = psm_pkg::FAULT_DSTACK;
               state_in = ST_FINISH;
            end else begin
               ds_raddr = ddep_m1[SW-1:0];
               rs_raddr = rdep_m1[SW-1:0];
               state_in = ST_POPA;
            end
         end
         ST_POPA: begin
            a_in     = ds_q;
            rtop_in  = rs_q;
            ds_raddr = ddep_m2[SW-1:0];
            state_in = ST_POPB;
         end
         ST_POPB: begin
            b_in     = ds_q;
            ddep_in  = ddep_ff - DW'(psm_pkg::op_pops(op));
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            npush_in = 2'd0;
            state_in = ST_FINISH;
            case (op)
               psm_pkg::OP_LIT: begin
                  if (ip_inc == IW'(psm_pkg::MEM_WORDS)) begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_RANGE;
                  end else begin
                     ip_in    = ip_inc;
                     pm_raddr = ip_inc[MW-1:0];
                     state_in = ST_MEMQ;
                  end
               end
               psm_pkg::OP_DUP: begin
                  v1_in = a_ff; v2_in = a_ff; npush_in = 2'd2; state_in = ST_PCHK;
               end
               psm_pkg::OP_SWAP: begin
                  v1_in = a_ff; v2_in = b_ff; npush_in = 2'd2; state_in = ST_PCHK;
               end
               psm_pkg::OP_PUSH: begin
                  if (rdep_ff == DW'(psm_pkg::STACK_DEPTH)) begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_RSTACK;
                  end else begin
                     rs_we    = 1'b1;
                     rs_wdata = a_ff;
                     rdep_in  = rdep_ff + DW'(1);
                  end
               end
               psm_pkg::OP_POP: begin
                  if (rdep_ff == DW'(0)) begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_RSTACK;
                  end else begin
                     rdep_in  = rdep_m1;
                     v1_in    = rtop_ff;
                     npush_in = 2'd1;
                     state_in = ST_PCHK;
                  end
               end
               psm_pkg::OP_JUMP: begin
                  if (tgt_ok) begin
                     ip_in = ip_tgt;
                  end else begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_RANGE;
                  end
               end
               psm_pkg::OP_CALL, psm_pkg::OP_CCALL: begin
                  if (op == psm_pkg::OP_CALL || b_ff != 32'd0) begin
                     if (rdep_ff == DW'(psm_pkg::STACK_DEPTH)) begin
                        stop_in  = 1'b1;
                        fault_in = psm_pkg::FAULT_RSTACK;
                     end else begin
                        rs_we    = 1'b1;
                        rs_wdata = ip_word;
                        rdep_in  = rdep_ff + DW'(1);
                        if (tgt_ok) begin
                           ip_in = ip_tgt;
                        end else begin
                           stop_in  = 1'b1;
                           fault_in = psm_pkg::FAULT_RANGE;
                        end
                     end
                  end
               end
               psm_pkg::OP_RET, psm_pkg::OP_ZRET: begin
                  if (op == psm_pkg::OP_ZRET && a_ff != 32'd0) begin
                     v1_in    = a_ff;
                     npush_in = 2'd1;
                     state_in = ST_PCHK;
                  end else if (rdep_ff == DW'(0)) begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_RSTACK;
                  end else begin
                     rdep_in = rdep_m1;
                     if (tgt_ok) begin
                        ip_in = ip_tgt;
                     end else begin
                        stop_in  = 1'b1;
                        fault_in = psm_pkg::FAULT_RANGE;
                     end
                  end
               end
               psm_pkg::OP_EQ, psm_pkg::OP_NE, psm_pkg::OP_LT, psm_pkg::OP_GT: begin
                  case (op)
                     psm_pkg::OP_EQ: v1_in = {32{b_ff == a_ff}};
                     psm_pkg::OP_NE: v1_in = {32{b_ff != a_ff}};
                     psm_pkg::OP_LT: v1_in = {32{$signed(b_ff) < $signed(a_ff)}};
                     default:        v1_in = {32{$signed(b_ff) > $signed(a_ff)}};
                  endcase
                  npush_in = 2'd1;
                  state_in = ST_PCHK;
               end
               psm_pkg::OP_FETCH: begin
                  if (a_ff[31]) begin
                     // negative addresses are environment queries
                     npush_in = 2'd1;
                     state_in = ST_PCHK;
                     if (a_ff == 32'hFFFF_FFFF) begin
                        v1_in = 32'(ddep_ff) + 32'd1;
                     end else if (a_ff == 32'hFFFF_FFFE) begin
                        v1_in = 32'(rdep_ff) + 32'd1;
                     end else if (a_ff == 32'hFFFF_FFFD) begin
                        v1_in = 32'(psm_pkg::MEM_WORDS);
                     end else if (a_ff == 32'hFFFF_FFFC) begin
                        v1_in = psm_pkg::MAX_INT;
                     end else if (a_ff == 32'hFFFF_FFFB) begin
                        v1_in = psm_pkg::MIN_INT;
                     end else begin
                        npush_in = 2'd0;
                        state_in = ST_FINISH;
                     end
                  end else if (a_ff >= 32'(psm_pkg::MEM_WORDS)) begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_RANGE;
                  end else begin
                     pm_raddr = a_ff[MW-1:0];
                     state_in = ST_MEMQ;
                  end
               end
               psm_pkg::OP_STORE: begin
                  if (a_ff[31] || a_ff >= 32'(psm_pkg::MEM_WORDS)) begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_RANGE;
                  end else begin
                     pm_we    = 1'b1;
                     pm_waddr = a_ff[MW-1:0];
                     pm_wdata = b_ff;
                  end
               end
               psm_pkg::OP_ADD, psm_pkg::OP_SUB, psm_pkg::OP_MUL, psm_pkg::OP_AND,
               psm_pkg::OP_OR, psm_pkg::OP_XOR, psm_pkg::OP_SHIFT: begin
                  case (op)
                     psm_pkg::OP_ADD: v1_in = b_ff + a_ff;
                     psm_pkg::OP_SUB: v1_in = b_ff - a_ff;
                     psm_pkg::OP_MUL: v1_in = mul_res;
                     psm_pkg::OP_AND: v1_in = b_ff & a_ff;
                     psm_pkg::OP_OR:  v1_in = b_ff | a_ff;
                     psm_pkg::OP_XOR: v1_in = b_ff ^ a_ff;
                     default:         v1_in = sh_res;
                  endcase
                  npush_in = 2'd1;
                  state_in = ST_PCHK;
               end
               psm_pkg::OP_DIVMOD: begin
                  if (a_ff == 32'd0) begin
                     stop_in  = 1'b1;
                     fault_in = psm_pkg::FAULT_DIV0;
                  end else begin
                     div_den_in  = a_ff[31] ? neg_a : a_ff;
                     div_quo_in  = b_ff[31] ? 32'd0 - b_ff : b_ff;
                     div_rem_in  = 33'd0;
                     div_cnt_in  = 5'd0;
                     div_qneg_in = a_ff[31] ^ b_ff[31];
                     div_rneg_in = b_ff[31];
                     state_in    = ST_DIV;
                  end
               end
               psm_pkg::OP_HALT: begin
                  stop_in  = 1'b1;
                  fault_in = psm_pkg::FAULT_HALT;
               end
               psm_pkg::OP_IOCOUNT: begin
                  v1_in = psm_pkg::IO_COUNT; npush_in = 2'd1; state_in = ST_PCHK;
               end
               psm_pkg::OP_IOQUERY: begin
                  v1_in = 32'd0; v2_in = a_ff; npush_in = 2'd2; state_in = ST_PCHK;
               end
               psm_pkg::OP_IO: begin
                  if (a_ff == 32'd0) begin
                     // the character is the entry under the device number
                     if (ddep_ff == DW'(0)) begin
                        stop_in  = 1'b1;
                        fault_in = psm_pkg::FAULT_DSTACK;
                     end else begin
                        ddep_in = ddep_m1;
                        cv_in   = 1'b1;
                        co_in   = b_ff[7:0];
                     end
                  end else if (a_ff == 32'd1) begin
                     v1_in    = {{24{req_ff.key_char[7]}}, req_ff.key_char};
                     npush_in = 2'd1;
                     state_in = ST_PCHK;
                  end
               end
               default: ;
            endcase
         end
         ST_MEMQ: begin
            v1_in    = pm_q;
            npush_in = 2'd1;
            state_in = ST_PCHK;
         end
         ST_DIV: begin
            if (div_sh >= {1'b0, div_den_ff}) begin
               div_rem_in = div_sh - {1'b0, div_den_ff};
               div_quo_in = {div_quo_ff[30:0], 1'b1};
            end else begin
               div_rem_in = div_sh;
               div_quo_in = {div_quo_ff[30:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               state_in = ST_DIVFIX;
            end
         end
         ST_DIVFIX: begin
            v1_in    = div_rneg_ff ? 32'd0 - div_rem_ff[31:0] : div_rem_ff[31:0];
            v2_in    = div_qneg_ff ? 32'd0 - div_quo_ff : div_quo_ff;
            npush_in = 2'd2;
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            if (push_end > (DW + 1)'(psm_pkg::STACK_DEPTH)) begin
               stop_in  = 1'b1;
               fault_in = psm_pkg::FAULT_DSTACK;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PUSH1;
            end
         end
         ST_PUSH1: begin
            ds_we    = 1'b1;
            ds_waddr = ddep_ff[SW-1:0];
            ds_wdata = v1_ff;
            ddep_in  = ddep_ff + DW'(1);
            state_in = (npush_ff == 2'd2) ? ST_PUSH2 : ST_FINISH;
         end
         ST_PUSH2: begin
            ds_we    = 1'b1;
            ds_waddr = ddep_ff[SW-1:0];
            ds_wdata = v2_ff;
            ddep_in  = ddep_ff + DW'(1);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (fire) begin
               if (req_ff.cmd == psm_pkg::CMD_EXEC && !stop_ff) begin
                  slot_in = slot_ff + 2'd1;
                  if (slot_ff == 2'd3) begin
                     ip_in = ip_inc;
                     if (ip_inc == IW'(psm_pkg::MEM_WORDS)) begin
                        stop_in  = 1'b1;
                        fault_in = psm_pkg::FAULT_RANGE;
                     end
                  end
               end
               rsp_in.read_value = rdval_ff;
               rsp_in.char_valid = cv_ff;
               rsp_in.char_out   = co_ff;
               rsp_in.halted     = stop_in;
               rsp_in.fault_code = fault_in;
               rsp_in.pc         = ip_in;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bundle_ff    <= 32'd0;
         slot_ff      <= 2'd0;
         ip_ff        <= '0;
         ddep_ff      <= '0;
         rdep_ff      <= '0;
         stop_ff      <= 1'b0;
         fault_ff     <= psm_pkg::FAULT_NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bundle_ff    <= bundle_in;
         slot_ff      <= slot_in;
         ip_ff        <= ip_in;
         ddep_ff      <= ddep_in;
         rdep_ff      <= rdep_in;
         stop_ff      <= stop_in;
         fault_ff     <= fault_in;
      end
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rtop_ff     <= rtop_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      npush_ff    <= npush_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      div_cnt_ff  <= div_cnt_in;
      div_qneg_ff <= div_qneg_in;
      div_rneg_ff <= div_rneg_in;
      cv_ff       <= cv_in;
      co_ff       <= co_in;
      rdval_ff    <= rdval_in;
   end

   psm_ram #(.WIDTH(psm_pkg::WORD_W), .DEPTH(psm_pkg::MEM_WORDS)) u_prog_ram (
      .clock   (clock),
      .wr_en   (pm_we),
      .wr_addr (pm_waddr),
      .wr_data (pm_wdata),
      .rd_addr (pm_raddr),
      .rd_data (pm_q)
   );

   psm_ram #(.WIDTH(psm_pkg::WORD_W), .DEPTH(psm_pkg::STACK_DEPTH)) u_data_stack (
      .clock   (clock),
      .wr_en   (ds_we),
      .wr_addr (ds_waddr),
      .wr_data (ds_wdata),
      .rd_addr (ds_raddr),
      .rd_data (ds_q)
   );

   psm_ram #(.WIDTH(psm_pkg::WORD_W), .DEPTH(psm_pkg::STACK_DEPTH)) u_ret_stack (
      .clock   (clock),
      .wr_en   (rs_we),
      .wr_addr (rs_waddr),
      .wr_data (rs_wdata),
      .rd_addr (rs_raddr),
      .rd_data (rs_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_ddep_bound: assert property (@(posedge clock) disable iff (reset)
      ddep_ff <= DW'(psm_pkg::STACK_DEPTH))
      else $error("data stack depth out of range");

   a_rdep_bound: assert property (@(posedge clock) disable iff (reset)
      rdep_ff <= DW'(psm_pkg::STACK_DEPTH))
      else $error("return stack depth out of range");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff)
      else $error("stop flag cleared without reset");

   a_fault_stop: assert property (@(posedge clock) disable iff (reset)
      (fault_ff != psm_pkg::FAULT_NONE) == stop_ff)
      else $error("fault code and stop flag disagree");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

endmodule

// ===== tb/tb_packed_stack_machine_core.sv =====
// ----------------------------------------------------------------------------
// tb_packed_stack_machine_core
// Drives write, read and execute commands into the stack core and checks every
// response against a cycle-free model of the core kept in this file. Programs
// are built on the fly so that they run a long time before the core stops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packed_stack_machine_core;
   import psm_pkg::*;

   localparam logic [1:0] CMD_IDLE = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int MAX_DEPTH_SEEN = 40;

   typedef struct {
      logic [31:0] dstk [STACK_DEPTH];
      logic [31:0] rstk [STACK_DEPTH];
      int          ddep;
      int          rdep;
      int          ip;
      logic [31:0] bundle;
      int          slot;
      bit          stop;
      logic [2:0]  fault;
   } core_state_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   core_state_t cs;
   logic [31:0] prog_mem [int];
   int          written_addrs [$];
   bit          dry_run;
   bit          touched_unwritten;

   req_type     pending_items [$];
   rsp_type     expected_status [$];
   int          n_items, n_chars, n_checked, err_count, cycles;

   packed_stack_machine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- core model ----------------

   function automatic logic [31:0] mem_rd(int a);
      if (!prog_mem.exists(a)) begin
         touched_unwritten = 1'b1;
         return 32'd0;
      end
      return prog_mem[a];
   endfunction

   function automatic void mem_wr(int a, logic [31:0] v);
      if (dry_run) return;
      if (!prog_mem.exists(a)) written_addrs.push_back(a);
      prog_mem[a] = v;
   endfunction

   function automatic void stop_with(logic [2:0] code);
      if (!cs.stop) begin
         cs.fault = code;
         cs.stop = 1'b1;
      end
   endfunction

   function automatic bit dpush(logic [31:0] v);
      if (cs.ddep >= STACK_DEPTH) begin
         stop_with(FAULT_DSTACK);
         return 1'b0;
      end
      cs.dstk[cs.ddep] = v;
      cs.ddep++;
      return 1'b1;
   endfunction

   function automatic bit dpop(output logic [31:0] v);
      v = '0;
      if (cs.ddep == 0) begin
         stop_with(FAULT_DSTACK);
         return 1'b0;
      end
      cs.ddep--;
      v = cs.dstk[cs.ddep];
      return 1'b1;
   endfunction

   function automatic bit rpush(logic [31:0] v);
      if (cs.rdep >= STACK_DEPTH) begin
         stop_with(FAULT_RSTACK);
         return 1'b0;
      end
      cs.rstk[cs.rdep] = v;
      cs.rdep++;
      return 1'b1;
   endfunction

   function automatic bit rpop(output logic [31:0] v);
      v = '0;
      if (cs.rdep == 0) begin
         stop_with(FAULT_RSTACK);
         return 1'b0;
      end
      cs.rdep--;
      v = cs.rstk[cs.rdep];
      return 1'b1;
   endfunction

   // targets land one before, the end-of-word advance steps onto them
   function automatic void go_to(longint nx);
      if (nx < 0 || nx >= MEM_WORDS) stop_with(FAULT_RANGE);
      else cs.ip = int'(nx - 1);
   endfunction

   function automatic logic [31:0] shifted(logic [31:0] b, int n);
      logic signed [31:0] sb;
      sb = b;
      if (n < 1) begin
         if (n < -31) return 32'd0;
         return b << (-n);
      end
      if (n >= 32) return b[31] ? 32'hFFFF_FFFF : 32'd0;
      return sb >>> n;
   endfunction

   function automatic int operand_count(logic [7:0] op);
      case (op)
         OP_SWAP, OP_CCALL, OP_EQ, OP_NE, OP_LT, OP_GT, OP_STORE, OP_ADD, OP_SUB,
         OP_MUL, OP_DIVMOD, OP_AND, OP_OR, OP_XOR, OP_SHIFT: return 2;
         OP_DUP, OP_DROP, OP_PUSH, OP_JUMP, OP_CALL, OP_FETCH, OP_ZRET,
         OP_IOQUERY, OP_IO: return 1;
         OP_NOP, OP_LIT, OP_POP, OP_RET, OP_HALT, OP_IOCOUNT: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic void run_slot(logic [7:0] op, logic [7:0] key,
                                    output bit cv, output logic [7:0] co);
      logic [31:0] a, b, v;
      int sa, sb, tmp, n;
      cv = 1'b0;
      co = '0;
      a = '0;
      b = '0;
      n = operand_count(op);
      if (n < 0) begin
         stop_with(FAULT_OPCODE);
         return;
      end
      if (n >= 1 && !dpop(a)) return;
      if (n == 2 && !dpop(b)) return;
      sa = a;
      sb = b;
      case (op)
         OP_LIT: begin
            if (cs.ip + 1 >= MEM_WORDS) stop_with(FAULT_RANGE);
            else begin
               cs.ip++;
               void'(dpush(mem_rd(cs.ip)));
            end
         end
         OP_DUP:  if (dpush(a)) void'(dpush(a));
         OP_SWAP: if (dpush(a)) void'(dpush(b));
         OP_PUSH: void'(rpush(a));
         OP_POP:  if (rpop(v)) void'(dpush(v));
         OP_JUMP: go_to(sa);
         OP_CALL: if (rpush(cs.ip)) go_to(sa);
         OP_CCALL: if (b != 0) if (rpush(cs.ip)) go_to(sa);
         OP_RET: begin
            if (rpop(v)) begin
               tmp = v;
               go_to(longint'(tmp) + 1);
            end
         end
         OP_EQ: void'(dpush(sb == sa ? 32'hFFFF_FFFF : 32'd0));
         OP_NE: void'(dpush(sb != sa ? 32'hFFFF_FFFF : 32'd0));
         OP_LT: void'(dpush(sb < sa ? 32'hFFFF_FFFF : 32'd0));
         OP_GT: void'(dpush(sb > sa ? 32'hFFFF_FFFF : 32'd0));
         OP_FETCH: begin
            // negative addresses are queries
            if (sa < 0) begin
               case (sa)
                  -1: void'(dpush(cs.ddep + 1));
                  -2: void'(dpush(cs.rdep + 1));
                  -3: void'(dpush(MEM_WORDS));
                  -4: void'(dpush(MAX_INT));
                  -5: void'(dpush(MIN_INT));
                  default: ;
               endcase
            end else if (sa >= MEM_WORDS) stop_with(FAULT_RANGE);
            else void'(dpush(mem_rd(sa)));
         end
         OP_STORE: begin
            if (sa < 0 || sa >= MEM_WORDS) stop_with(FAULT_RANGE);
            else mem_wr(sa, b);
         end
         OP_ADD: void'(dpush(b + a));
         OP_SUB: void'(dpush(b - a));
         OP_MUL: void'(dpush(b * a));
         OP_DIVMOD: begin
            if (a == 0) stop_with(FAULT_DIV0);
            else if (b == MIN_INT && a == 32'hFFFF_FFFF) begin
               if (dpush(32'd0)) void'(dpush(MIN_INT));
            end else begin
               if (dpush(sb % sa)) void'(dpush(sb / sa));
            end
         end
         OP_AND:   void'(dpush(b & a));
         OP_OR:    void'(dpush(b | a));
         OP_XOR:   void'(dpush(b ^ a));
         OP_SHIFT: void'(dpush(shifted(b, sa)));
         OP_ZRET: begin
            if (a == 0) begin
               if (rpop(v)) begin
                  tmp = v;
                  go_to(longint'(tmp) + 1);
               end
            end else void'(dpush(a));
         end
         OP_HALT:    stop_with(FAULT_HALT);
         OP_IOCOUNT: void'(dpush(IO_COUNT));
         OP_IOQUERY: if (dpush(32'd0)) void'(dpush(a));
         OP_IO: begin
            if (a == 0) begin
               if (dpop(v)) begin
                  cv = 1'b1;
                  co = v[7:0];
               end
            end else if (a == 1) void'(dpush({{24{key[7]}}, key}));
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type core_step(req_type r);
      rsp_type o;
      logic [31:0] rd;
      bit cv;
      logic [7:0] co;
      rd = '0;
      cv = 1'b0;
      co = '0;
      case (r.cmd)
         CMD_WRITE: mem_wr(r.mem_addr, r.mem_value);
         CMD_READ:  rd = mem_rd(r.mem_addr);
         CMD_EXEC: begin
            if (!cs.stop) begin
               if (cs.slot == 0) cs.bundle = mem_rd(cs.ip);
               run_slot(cs.bundle[8*cs.slot +: 8], r.key_char, cv, co);
               if (!cs.stop) begin
                  cs.slot = (cs.slot + 1) % 4;
                  if (cs.slot == 0) begin
                     cs.ip++;
                     if (cs.ip >= MEM_WORDS) stop_with(FAULT_RANGE);
                  end
               end
            end
         end
         default: ;
      endcase
      o.read_value = rd;
      o.char_valid = cv;
      o.char_out   = co;
      o.halted     = cs.stop;
      o.fault_code = cs.fault;
      o.pc         = cs.ip[16:0];
      return o;
   endfunction

   // ---------------- stimulus ----------------

   function automatic void send(req_type r);
      rsp_type p;
      p = core_step(r);
      expected_status.push_back(p);
      pending_items.push_back(r);
      n_items++;
      if (p.char_valid) n_chars++;
   endfunction

   function automatic req_type make_item(logic [1:0] cmd, int addr, logic [31:0] val);
      req_type r;
      r.cmd       = cmd;
      r.mem_addr  = addr;
      r.mem_value = val;
      r.key_char  = $urandom;
      return r;
   endfunction

   function automatic void write_word(int addr, logic [31:0] val);
      send(make_item(CMD_WRITE, addr, val));
   endfunction

   function automatic void exec_slot(logic [7:0] key);
      req_type r;
      r = make_item(CMD_EXEC, $urandom_range(0, 65535), $urandom);
      r.key_char = key;
      send(r);
   endfunction

   function automatic logic [31:0] ops4(logic [7:0] s0, logic [7:0] s1,
                                        logic [7:0] s2, logic [7:0] s3);
      return {s3, s2, s1, s0};
   endfunction

   function automatic logic [31:0] rand_literal();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 63);
         1: return -$urandom_range(1, 6);
         2: return $urandom;
         3: case ($urandom_range(0, 3))
               0: return MAX_INT;
               1: return MIN_INT;
               2: return 32'd0;
               default: return 32'hFFFF_FFFF;
            endcase
         4: return $urandom_range(0, 40);
         5: return -$urandom_range(0, 40);
         6: return $urandom_range(0, 1);
         default: return $urandom_range(32, 126);
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      logic [7:0] op;
      for (int k = 0; k < 4; k++) begin
         op = ($urandom_range(0, 9) < 3) ? OP_LIT : 8'($urandom_range(0, 29));
         if (op == OP_HALT) op = OP_NOP;
         w[8*k +: 8] = op;
      end
      return w;
   endfunction

   // runs the word at ip on a copy of the state; fails words that stop, read unwritten memory or pass MAX_DEPTH_SEEN
   function automatic bit word_runs_clean(logic [31:0] w, logic [7:0] keys [4]);
      core_state_t saved;
      bit had, ok;
      logic [31:0] old;
      rsp_type o;
      saved = cs;
      had = prog_mem.exists(cs.ip);
      old = had ? prog_mem[cs.ip] : '0;
      prog_mem[cs.ip] = w;
      dry_run = 1'b1;
      touched_unwritten = 1'b0;
      for (int k = 0; k < 4; k++) begin
         o = core_step(make_item(CMD_EXEC, 0, 0));
      end
      ok = !cs.stop && !touched_unwritten && cs.ddep <= MAX_DEPTH_SEEN
           && cs.rdep <= MAX_DEPTH_SEEN;
      cs = saved;
      dry_run = 1'b0;
      if (had) prog_mem[cs.ip] = old;
      else prog_mem.delete(cs.ip);
      return ok;
   endfunction

   function automatic void random_word();
      logic [31:0] w;
      logic [7:0] keys [4];
      int nl;
      bit good;
      for (int k = 0; k < 4; k++) keys[k] = $urandom;
      if ($urandom_range(0, 5) == 0)
         write_word($urandom_range(0, 3) == 0 ? 65535 : $urandom_range(4096, 65535),
                    $urandom);
      good = 1'b0;
      for (int t = 0; t < 12 && !good; t++) begin
         if (t == 0 && prog_mem.exists(cs.ip) && $urandom_range(0, 1)) begin
            w = prog_mem[cs.ip];
         end else begin
            w = rand_word();
            nl = 0;
            for (int k = 0; k < 4; k++) if (w[8*k +: 8] == OP_LIT) nl++;
            for (int k = 1; k <= nl; k++)
               if (cs.ip + k < MEM_WORDS) write_word(cs.ip + k, rand_literal());
         end
         good = word_runs_clean(w, keys);
      end
      if (!good) w = '0;
      write_word(cs.ip, w);
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(0, 6) == 0) begin
            if ($urandom_range(0, 1))
               send(make_item(CMD_IDLE, $urandom_range(0, 65535), $urandom));
            else
               send(make_item(CMD_READ,
                  written_addrs[$urandom_range(0, written_addrs.size() - 1)], $urandom));
         end
         exec_slot(keys[k]);
      end
   endfunction

   function automatic void directed_program();
      int guard;
      write_word(0,  ops4(OP_LIT, OP_LIT, OP_DIVMOD, OP_NOP));
      write_word(1,  MIN_INT);
      write_word(2,  32'hFFFF_FFFF);
      write_word(3,  ops4(OP_LIT, OP_LIT, OP_SHIFT, OP_DROP));
      write_word(4,  32'hFFFF_FFFF);
      write_word(5,  32'd40);
      write_word(6,  ops4(OP_LIT, OP_LIT, OP_SHIFT, OP_DROP));
      write_word(7,  32'd5);
      write_word(8,  -32'd40);
      write_word(9,  ops4(OP_LIT, OP_FETCH, OP_LIT, OP_FETCH));
      write_word(10, -32'd1);
      write_word(11, -32'd2);
      write_word(12, ops4(OP_LIT, OP_FETCH, OP_LIT, OP_FETCH));
      write_word(13, -32'd3);
      write_word(14, -32'd4);
      write_word(15, ops4(OP_LIT, OP_FETCH, OP_LIT, OP_FETCH));
      write_word(16, -32'd5);
      write_word(17, -32'd7);
      write_word(18, ops4(OP_LIT, OP_LIT, OP_IO, OP_IOCOUNT));
      write_word(19, 32'd65);
      write_word(20, 32'd0);
      write_word(21, ops4(OP_LIT, OP_IO, OP_IOQUERY, OP_DROP));
      write_word(22, 32'd1);
      write_word(23, ops4(OP_LIT, OP_LIT, OP_NOP, OP_NOP));
      write_word(24, 32'd1);
      write_word(25, 32'd31);
      write_word(26, ops4(OP_CCALL, OP_NOP, OP_NOP, OP_NOP));
      write_word(27, ops4(OP_LIT, OP_JUMP, OP_NOP, OP_NOP));
      write_word(28, 32'd40);
      write_word(31, ops4(OP_LIT, OP_ZRET, OP_LIT, OP_ZRET));
      write_word(32, 32'd5);
      write_word(33, 32'd0);
      write_word(40, ops4(OP_PUSH, OP_POP, OP_DUP, OP_SWAP));
      write_word(41, ops4(OP_EQ, OP_NE, OP_LT, OP_GT));
      write_word(42, ops4(OP_LIT, OP_LIT, OP_STORE, OP_NOP));
      write_word(43, 32'd123);
      write_word(44, 32'd200);
      write_word(45, ops4(OP_LIT, OP_FETCH, OP_ADD, OP_SUB));
      write_word(46, 32'd200);
      write_word(47, ops4(OP_MUL, OP_AND, OP_OR, OP_XOR));
      write_word(65535, MIN_INT);
      write_word(4096, MAX_INT);
      send(make_item(CMD_READ, 65535, 0));
      send(make_item(CMD_READ, 4096, 32'hFFFF_FFFF));
      send(make_item(CMD_IDLE, 65535, MIN_INT));
      guard = 0;
      while (!(cs.ip == 48 && cs.slot == 0) && !cs.stop && guard < 400) begin
         exec_slot($urandom);
         guard++;
      end
      send(make_item(CMD_READ, 200, 0));
   endfunction

   function automatic void stopping_word();
      logic [7:0] op;
      case ($urandom_range(0, 4))
         0: op = OP_DIVMOD;
         1: op = OP_HALT;
         2: op = $urandom_range(30, 255);
         3: op = OP_POP;
         default: op = OP_RET;
      endcase
      write_word(cs.ip + 1, 32'd7);
      write_word(cs.ip + 2, 32'd0);
      write_word(cs.ip, ops4(OP_LIT, OP_LIT, op, OP_NOP));
      for (int k = 0; k < 4; k++) exec_slot($urandom);
      while (!cs.stop) begin
         if (cs.slot == 0) write_word(cs.ip, ops4(OP_HALT, OP_NOP, OP_NOP, OP_NOP));
         exec_slot($urandom);
      end
      for (int k = 0; k < 5; k++) exec_slot($urandom);
      send(make_item(CMD_READ, 0, 0));
   endfunction

   initial begin
      cs.ddep = 0;
      cs.rdep = 0;
      cs.ip = 0;
      cs.bundle = '0;
      cs.slot = 0;
      cs.stop = 1'b0;
      cs.fault = FAULT_NONE;
      dry_run = 1'b0;
      directed_program();
      while (n_items < RANDOM_ITEMS && !cs.stop) random_word();
      stopping_word();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() > 0 || expected_status.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d items sent, %0d responses checked, %0d characters emitted",
               n_items, n_checked, n_chars);
      $display("core stopped at pc %0h with fault code %0d", cs.ip[16:0], cs.fault);
      if (err_count == 0) begin
         $display("tb_packed_stack_machine_core: done, clean");
      end else begin
         $display("tb_packed_stack_machine_core: done, errors");
      end
      $finish;
   end

   // ---------------- driver ----------------

   int  req_gap;
   bit  req_busy_mode;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if ($urandom_range(0, 40) == 0) req_busy_mode = !req_busy_mode;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            req_gap = req_busy_mode ? 0 : $urandom_range(0, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------

   int  rsp_hold;
   bit  rsp_busy_mode;

   function automatic void check_field(string nm, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", nm, e, a);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("response with nothing expected");
               err_count++;
            end else begin
               e = expected_status.pop_front();
               check_field("read_value", e.read_value, rsp_data.read_value);
               check_field("char_valid", e.char_valid, rsp_data.char_valid);
               check_field("char_out", e.char_out, rsp_data.char_out);
               check_field("halted", e.halted, rsp_data.halted);
               check_field("fault_code", e.fault_code, rsp_data.fault_code);
               check_field("pc", e.pc, rsp_data.pc);
            end
            n_checked++;
            if ($urandom_range(0, 40) == 0) rsp_busy_mode = !rsp_busy_mode;
            // one long hold so the core backs up into its input
            if (n_checked == 400) rsp_hold = 300;
            else rsp_hold = rsp_busy_mode ? 0 : $urandom_range(0, 4);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_packed_stack_machine_core: done, errors");
         $finish;
      end
   end

endmodule
